/* design/kr_pkg.sv */
package kr_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 16;
    localparam int COUNT_W = 8;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_UPDATE = 2'd2,
        REQ_DELETE = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

endpackage

/* design/kr_if.sv */
interface kr_req_if;
    import kr_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;

    modport source (output valid, output req_type, output key, output value, input ready);
    modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface kr_rsp_if;
    import kr_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [VAL_W-1:0]   found_value;
    logic [COUNT_W-1:0] entry_count;

    modport source (output valid, output status, output found_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input found_value, input entry_count,
                    output ready);
endinterface

/* design/kr_mem.sv */
module kr_mem #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_wr_addr,
    input  kr_pkg::t_entry                 i_wr_data,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_rd_addr,
    output kr_pkg::t_entry                 o_rd_data
);
    import kr_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/kr_ctrl.sv */
module kr_ctrl #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    kr_req_if.sink                         i_req,
    kr_rsp_if.source                       o_rsp,
    output logic                           o_wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_wr_addr,
    output kr_pkg::t_entry                 o_wr_data,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_rd_addr,
    input  kr_pkg::t_entry                 i_rd_data
);
    import kr_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_RESP  = 4'b1000
    } t_state;

    t_state             r_state,  n_state;
    logic [CW-1:0]      r_count,  n_count;
    logic               r_out_valid, n_out_valid;
    t_req_type          r_req,    n_req;
    logic [KEY_W-1:0]   r_key,    n_key;
    logic [VAL_W-1:0]   r_val,    n_val;
    logic [IW-1:0]      r_idx,    n_idx;
    t_status            r_status, n_status;
    logic [VAL_W-1:0]   r_found,  n_found;
    t_status            r_out_status, n_out_status;
    logic [VAL_W-1:0]   r_out_found,  n_out_found;
    logic [COUNT_W-1:0] r_out_count,  n_out_count;

    logic [IW-1:0] idx_nxt;
    logic          scan_last;
    logic          shift_last;

    assign idx_nxt    = r_idx + IW'(1);
    assign scan_last  = (CW'(r_idx) + CW'(1)) >= r_count;
    assign shift_last = (CW'(r_idx) + CW'(2)) >= r_count;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_req        = r_req;
        n_key        = r_key;
        n_val        = r_val;
        n_idx        = r_idx;
        n_status     = r_status;
        n_found      = r_found;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_idx;
        o_wr_data    = '{key: r_key, value: r_val};
        o_rd_addr    = idx_nxt;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_rd_addr = '0;
                if (i_req.valid) begin
                    n_req    = t_req_type'(i_req.req_type);
                    n_key    = i_req.key;
                    n_val    = i_req.value;
                    n_idx    = '0;
                    n_found  = '0;
                    n_status = ST_DONE;
                    if (t_req_type'(i_req.req_type) == REQ_APPEND) begin
                        n_state = S_RESP;
                        if (r_count >= CW'(TABLE_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = IW'(r_count);
                            o_wr_data = '{key: i_req.key, value: i_req.value};
                            n_count   = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_MISSING;
                        n_state  = S_RESP;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_rd_data.key == r_key) begin
                    n_status = ST_DONE;
                    n_state  = S_RESP;
                    case (r_req)
                        REQ_SEARCH: begin
                            n_found = i_rd_data.value;
                        end
                        REQ_UPDATE: begin
                            o_wr_en = 1'b1;
                        end
                        REQ_DELETE: begin
                            if (scan_last) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                n_state = S_SHIFT;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end else if (scan_last) begin
                    n_status = ST_MISSING;
                    n_state  = S_RESP;
                end else begin
                    n_idx = idx_nxt;
                end
            end
            S_SHIFT: begin
                o_wr_en   = 1'b1;
                o_wr_data = i_rd_data;
                o_rd_addr = r_idx + IW'(2);
                n_idx     = idx_nxt;
                if (shift_last) begin
                    n_count = r_count - CW'(1);
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_found;
                    n_out_count  = COUNT_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_key        <= n_key;
        r_val        <= n_val;
        r_idx        <= n_idx;
        r_status     <= n_status;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_value = r_out_found;
    assign o_rsp.entry_count = r_out_count;

endmodule

/* design/keyed_record_table_core.sv */
// Keyed record table: a packed, unsorted table of key/value records.
// i_req carries one request per transaction (req_type, key, value):
// append, search, update value, or delete by key. o_rsp returns one
// transaction per request: status, found_value (nonzero only on a
// successful search) and entry_count after the request.
// The records live in one single-port-write, registered-read memory of
// TABLE_DEPTH entries; the controller scans it one entry per cycle.
// Search, update and delete act on the first record whose key matches,
// scanning from index 0, or end with the key absent; delete shifts
// each record behind the match down by one entry.
// One request is in work at a time; i_req.ready is high while idle, also
// while a finished response still waits on o_rsp.
// When o_rsp stalls, the response is held and the next result waits in
// the controller until the output register frees up.
// Reset empties the table and clears o_rsp.valid; memory contents are not
// cleared, entries at or above the count are never used.
module keyed_record_table_core #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    kr_req_if.sink   i_req,
    kr_rsp_if.source o_rsp
);
    import kr_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;
    logic [IW-1:0] rd_addr;
    t_entry        rd_data;

    kr_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    kr_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import kr_pkg::*;

    localparam int DEPTH        = 128;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CALM_ITEMS   = 200;
    localparam int POOL_SIZE    = 16;
    localparam int SCRIPT_LEN   = 20;
    localparam int DRAIN_CYCLES = 600;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct packed {
        t_status            status;
        logic [VAL_W-1:0]   found;
        logic [COUNT_W-1:0] count;
    } table_reply_t;

    typedef struct {
        t_req_type        kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        bit               typed;
        table_reply_t     reply;
    } script_row_t;

    typedef enum int {
        SEG_FILL,
        SEG_DRAIN,
        SEG_MIXED
    } segment_t;

    logic clk;
    logic rst_n;

    kr_req_if req_bus ();
    kr_rsp_if rsp_bus ();

    keyed_record_table_core #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    logic [KEY_W-1:0]   table_keys [DEPTH];
    logic [VAL_W-1:0]   table_values [DEPTH];
    int                 held;
    logic [KEY_W-1:0]   key_pool [POOL_SIZE];
    table_reply_t       pending_replies [$];
    script_row_t        script [SCRIPT_LEN];
    int                 errors;
    longint             cycles;
    bit                 calm;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d replies outstanding", $time, pending_replies.size());
            $display("** keyed_record_table_core: FAILED **");
            $finish;
        end
    end

    function automatic table_reply_t apply_request(input t_req_type kind,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [VAL_W-1:0] value);
        table_reply_t reply;
        int           hit;
        reply.status = ST_DONE;
        reply.found  = '0;
        hit          = held;
        if (kind == REQ_APPEND) begin
            if (held >= DEPTH) begin
                reply.status = ST_FULL;
            end else begin
                table_keys[held]   = key;
                table_values[held] = value;
                held++;
            end
        end else begin
            for (int i = 0; i < held; i++) begin
                if (table_keys[i] == key) begin
                    hit = i;
                    break;
                end
            end
            if (hit >= held) begin
                reply.status = ST_MISSING;
            end else if (kind == REQ_SEARCH) begin
                reply.found = table_values[hit];
            end else if (kind == REQ_UPDATE) begin
                table_values[hit] = value;
            end else begin
                for (int j = hit; j + 1 < held; j++) begin
                    table_keys[j]   = table_keys[j + 1];
                    table_values[j] = table_values[j + 1];
                end
                held--;
            end
        end
        reply.count = COUNT_W'(held);
        return reply;
    endfunction

    task automatic issue(input t_req_type kind, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] value, input bit typed,
                         input table_reply_t typed_reply);
        table_reply_t predicted;
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= kind;
        req_bus.key      <= key;
        req_bus.value    <= value;
        do @(posedge clk); while (!req_bus.ready);
        predicted = apply_request(kind, key, value);
        pending_replies.push_back(typed ? typed_reply : predicted);
    endtask

    // hold ready in random stretches, stall in bursts
    initial begin
        rsp_bus.ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!calm && $urandom_range(0, 1) == 1) begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        table_reply_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected transaction status=%0d found=%0h count=%0d",
                         $time, rsp_bus.status, rsp_bus.found_value, rsp_bus.entry_count);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                if (rsp_bus.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp_bus.status);
                    errors++;
                end
                if (rsp_bus.found_value !== want.found) begin
                    $display("%0t: found_value expected %0h actual %0h",
                             $time, want.found, rsp_bus.found_value);
                    errors++;
                end
                if (rsp_bus.entry_count !== want.count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.count, rsp_bus.entry_count);
                    errors++;
                end
            end
        end
    end

    initial begin
        table_reply_t     none;
        segment_t         seg;
        int               seg_len;
        int               gap_pct;
        int               sent;
        int               roll;
        t_req_type        kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;

        errors           = 0;
        cycles           = 0;
        calm             = 1'b0;
        held             = 0;
        none             = '0;
        rst_n            = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.req_type = REQ_APPEND;
        req_bus.key      = '0;
        req_bus.value    = '0;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        script[0]  = '{REQ_SEARCH, 32'h0000_0000, 16'h0000, 1'b1, '{ST_MISSING, 16'h0, 8'd0}};
        script[1]  = '{REQ_UPDATE, 32'hFFFF_FFFF, 16'h0001, 1'b1, '{ST_MISSING, 16'h0, 8'd0}};
        script[2]  = '{REQ_DELETE, 32'h0000_0000, 16'h0000, 1'b1, '{ST_MISSING, 16'h0, 8'd0}};
        script[3]  = '{REQ_APPEND, 32'h0000_0000, 16'h0000, 1'b1, '{ST_DONE, 16'h0, 8'd1}};
        script[4]  = '{REQ_APPEND, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{ST_DONE, 16'h0, 8'd2}};
        script[5]  = '{REQ_SEARCH, 32'hFFFF_FFFF, 16'h0000, 1'b1, '{ST_DONE, 16'hFFFF, 8'd2}};
        script[6]  = '{REQ_SEARCH, 32'h0000_0000, 16'hFFFF, 1'b1, '{ST_DONE, 16'h0, 8'd2}};
        script[7]  = '{REQ_APPEND, 32'hFFFF_FFFF, 16'h1234, 1'b1, '{ST_DONE, 16'h0, 8'd3}};
        script[8]  = '{REQ_SEARCH, 32'hFFFF_FFFF, 16'h0000, 1'b0, none};
        script[9]  = '{REQ_UPDATE, 32'hFFFF_FFFF, 16'hA5A5, 1'b0, none};
        script[10] = '{REQ_SEARCH, 32'hFFFF_FFFF, 16'h0000, 1'b0, none};
        script[11] = '{REQ_DELETE, 32'hFFFF_FFFF, 16'h0000, 1'b0, none};
        script[12] = '{REQ_SEARCH, 32'hFFFF_FFFF, 16'h0000, 1'b0, none};
        script[13] = '{REQ_APPEND, 32'h5A5A_5A5A, 16'h8000, 1'b1, '{ST_DONE, 16'h0, 8'd3}};
        script[14] = '{REQ_DELETE, 32'h0000_0000, 16'h0000, 1'b0, none};
        script[15] = '{REQ_SEARCH, 32'h5A5A_5A5A, 16'h0000, 1'b0, none};
        script[16] = '{REQ_UPDATE, 32'h1234_5678, 16'h7FFF, 1'b1, '{ST_MISSING, 16'h0, 8'd2}};
        script[17] = '{REQ_DELETE, 32'h5A5A_5A5A, 16'h0000, 1'b0, none};
        script[18] = '{REQ_DELETE, 32'hFFFF_FFFF, 16'h0000, 1'b0, none};
        script[19] = '{REQ_SEARCH, 32'hFFFF_FFFF, 16'h0000, 1'b1, '{ST_MISSING, 16'h0, 8'd0}};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i]) begin
            issue(script[i].kind, script[i].key, script[i].value, script[i].typed,
                  script[i].reply);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            seg     = segment_t'($urandom_range(0, 2));
            gap_pct = $urandom_range(0, 1) * 30;
            seg_len = (seg == SEG_FILL) ? DEPTH - held + $urandom_range(1, 6)
                                        : $urandom_range(20, 150);
            for (int n = 0; n < seg_len && sent < RANDOM_ITEMS; n++) begin
                calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
                if (sent == RANDOM_ITEMS / 2) begin
                    req_bus.valid <= 1'b0;
                    do @(posedge clk); while (pending_replies.size() != 0);
                end else if (!calm && $urandom_range(1, 100) <= gap_pct) begin
                    req_bus.valid <= 1'b0;
                    repeat ($urandom_range(1, 14)) @(posedge clk);
                end

                roll = $urandom_range(1, 100);
                case (seg)
                    SEG_FILL: begin
                        kind = (roll <= 85) ? REQ_APPEND : t_req_type'($urandom_range(0, 3));
                    end
                    SEG_DRAIN: begin
                        if (roll <= 65)      kind = REQ_DELETE;
                        else if (roll <= 80) kind = REQ_APPEND;
                        else                 kind = t_req_type'($urandom_range(1, 2));
                    end
                    default: begin
                        kind = t_req_type'($urandom_range(0, 3));
                    end
                endcase

                roll = $urandom_range(1, 100);
                if (kind == REQ_APPEND) begin
                    key = (roll <= 50) ? key_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
                end else if (held > 0 && roll <= 60) begin
                    key = table_keys[$urandom_range(0, held - 1)];
                end else if (roll <= 85) begin
                    key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                end else begin
                    key = $urandom;
                end

                roll = $urandom_range(1, 100);
                if (roll <= 10)      value = '0;
                else if (roll <= 20) value = '1;
                else                 value = VAL_W'($urandom_range(0, 65535));

                issue(kind, key, value, 1'b0, none);
                sent++;
            end
        end

        req_bus.valid <= 1'b0;
        do @(posedge clk); while (pending_replies.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0) begin
            $display("** keyed_record_table_core: PASSED **");
        end else begin
            $display("** keyed_record_table_core: FAILED **");
        end
        $finish;
    end

endmodule
